@@ hdl/sui_pkg.sv @@
// ----------------------------------------------------------------------------
// sui_pkg: shared types and constants for the interval union table
// Widths, table depth, action and status codes, the entry record and the
// per-cell control group.
// ----------------------------------------------------------------------------
package sui_pkg;

  localparam int DEPTH       = 16;
  localparam int HEIGHT_BITS = 32;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // input word action codes
  typedef logic [1:0] action_t;
  localparam action_t ACT_CLEAR  = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_DUMP   = 2'd2;

  // result word status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // one table entry; heights are signed two's complement bit patterns
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] bottom;
    logic [HEIGHT_BITS-1:0] top;
    logic [TAG_BITS-1:0]    ftag;
    logic [TAG_BITS-1:0]    ctag;
  } entry_t;

  // control for one cell of the chain
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

@@ hdl/sui_cell.sv @@
// ----------------------------------------------------------------------------
// sui_cell: one storage cell of the interval chain
// Holds one entry, takes its upper neighbor's entry on a shift or a written
// entry on a load, and flags whether a probe height falls inside its entry.
// ----------------------------------------------------------------------------
module sui_cell (
  input  logic                             clk,
  input  sui_pkg::cell_ctl_t               ctl,
  input  sui_pkg::entry_t                  next_in,
  input  sui_pkg::entry_t                  load_in,
  input  logic [sui_pkg::HEIGHT_BITS-1:0]  probe,
  output sui_pkg::entry_t                  q,
  output logic                             hit
);

  sui_pkg::entry_t q_r;

  // load wins over shift; payload needs no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= load_in;
    end else if (ctl.shift) begin
      q_r <= next_in;
    end
  end

  assign q   = q_r;
  // signed containment test: bottom <= probe <= top
  assign hit = ($signed(q_r.bottom) <= $signed(probe)) &&
               ($signed(probe) <= $signed(q_r.top));

endmodule

@@ hdl/sorted_interval_union_table.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_union_table: sorted, non-overlapping height interval table
// Channel | ports                                         | direction
// in      | in_valid, in_stall, in_action, in_new_*        | word in
// out     | out_valid, out_stall, out_status ... out_last  | word out
// Entries live in a chain of cells that shifts toward cell 0. An insert
// streams all n entries out of cell 0 through one merge register and writes
// the merged words back at the chain tail, then posts the result. Clear and
// rejected inserts post only a status word; a dump sends one entry per cycle
// while the output is not stalled. Reset (rst_n low, synchronous) empties the table.
// A stalled output holds its word; the block takes no new word until the
// current one has finished its pass.
// ----------------------------------------------------------------------------
module sorted_interval_union_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [sui_pkg::HEIGHT_BITS-1:0]   in_new_bottom,
  input  logic [sui_pkg::HEIGHT_BITS-1:0]   in_new_top,
  input  logic [sui_pkg::TAG_BITS-1:0]      in_new_floor_tag,
  input  logic [sui_pkg::TAG_BITS-1:0]      in_new_ceiling_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [sui_pkg::CNT_W-1:0]         out_entry_count,
  output logic                              out_entry_valid,
  output logic [sui_pkg::HEIGHT_BITS-1:0]   out_bottom,
  output logic [sui_pkg::HEIGHT_BITS-1:0]   out_top,
  output logic [sui_pkg::TAG_BITS-1:0]      out_floor_tag,
  output logic [sui_pkg::TAG_BITS-1:0]      out_ceiling_tag,
  output logic                              out_last
);

  localparam int DEPTH = sui_pkg::DEPTH;
  localparam int CNT_W = sui_pkg::CNT_W;
  localparam int IDX_W = sui_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_MERGE, S_DUMP, S_RESP} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r, tail_r, rem_r, dump_idx_r;
  logic                  newpend_r, pv_r;
  sui_pkg::entry_t       p_r, new_r;
  sui_pkg::status_t      status_r;

  logic                  out_valid_r, out_entry_valid_r, out_last_r;
  sui_pkg::status_t      out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  sui_pkg::entry_t       out_entry_r;

  sui_pkg::entry_t       cell_q [DEPTH];
  sui_pkg::cell_ctl_t    cell_ctl [DEPTH];
  logic [DEPTH-1:0]      hit_v, used_v;

  sui_pkg::entry_t       c0, e, push_data, in_entry;
  logic                  in_fire, out_free, any_hit, post;
  logic                  take_new, pop, push, finishing, joins, grow;
  logic [CNT_W-1:0]      push_pos;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sui_pkg::entry_t nxt_entry;
    if (i == DEPTH - 1) begin : g_end
      assign nxt_entry = '0;
    end else begin : g_mid
      assign nxt_entry = cell_q[i+1];
    end
    assign used_v[i]          = CNT_W'(i) < count_r;
    assign cell_ctl[i].shift  = pop;
    assign cell_ctl[i].load   = push && (push_pos[IDX_W-1:0] == IDX_W'(i));

    sui_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .next_in (nxt_entry),
      .load_in (push_data),
      .probe   (in_new_bottom),
      .q       (cell_q[i]),
      .hit     (hit_v[i])
    );
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // a result word is loaded this cycle
  assign post     = (state_r inside {S_DUMP, S_RESP}) && out_free;
  assign any_hit  = |(hit_v & used_v);
  assign c0       = cell_q[0];
  assign in_entry = '{bottom: in_new_bottom, top: in_new_top,
                      ftag: in_new_floor_tag, ctag: in_new_ceiling_tag};

  // merge stream: pick the next word in bottom order, fold it into p_r
  always_comb begin
    take_new  = newpend_r && ((rem_r == '0) ||
                ($signed(c0.bottom) > $signed(new_r.bottom)));
    e         = take_new ? new_r : c0;
    finishing = !newpend_r && (rem_r == '0);
    joins     = pv_r && ($signed(e.bottom) <= $signed(p_r.top));
    // touching the last entry's top takes the new ceiling unconditionally
    grow      = ($signed(e.top) > $signed(p_r.top)) ||
                (take_new && (rem_r == '0) && (e.bottom == p_r.top));
    pop       = 1'b0;
    push      = 1'b0;
    push_data = p_r;
    push_pos  = tail_r;
    case (state_r)
      S_MERGE: begin
        pop      = !take_new && (rem_r != '0);
        push     = finishing ? pv_r : (pv_r && !joins);
        push_pos = tail_r - CNT_W'(pop);
      end
      S_DUMP: begin
        // rotate: cell 0 goes back to the tail as it is sent out
        pop       = out_free;
        push      = out_free;
        push_data = c0;
        push_pos  = count_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // control, merge register and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      newpend_r   <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_action)
              sui_pkg::ACT_CLEAR: begin
                count_r  <= '0;
                status_r <= sui_pkg::ST_OK;
                state_r  <= S_RESP;
              end
              sui_pkg::ACT_INSERT: begin
                if ($signed(in_new_top) < $signed(in_new_bottom)) begin
                  status_r <= sui_pkg::ST_INVERTED;
                  state_r  <= S_RESP;
                end else if (count_r == CNT_W'(DEPTH) && !any_hit) begin
                  status_r <= sui_pkg::ST_FULL;
                  state_r  <= S_RESP;
                end else begin
                  status_r  <= sui_pkg::ST_OK;
                  state_r   <= S_MERGE;
                  rem_r     <= count_r;
                  tail_r    <= count_r;
                  newpend_r <= 1'b1;
                  pv_r      <= 1'b0;
                  new_r     <= in_entry;
                end
              end
              sui_pkg::ACT_DUMP: begin
                dump_idx_r <= '0;
                status_r   <= sui_pkg::ST_OK;
                state_r    <= (count_r != '0) ? S_DUMP : S_RESP;
              end
              default: begin
                status_r <= sui_pkg::ST_OK;
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_MERGE: begin
          tail_r <= tail_r - CNT_W'(pop) + CNT_W'(push);
          if (finishing) begin
            count_r <= tail_r + CNT_W'(pv_r);
            pv_r    <= 1'b0;
            state_r <= S_RESP;
          end else begin
            if (pop) begin
              rem_r <= rem_r - CNT_W'(1);
            end
            if (take_new) begin
              newpend_r <= 1'b0;
            end
            pv_r <= 1'b1;
            if (!pv_r || !joins) begin
              p_r <= e;
            end else if (grow) begin
              p_r.top  <= e.top;
              p_r.ctag <= e.ctag;
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_status_r      <= sui_pkg::ST_OK;
            out_count_r       <= count_r;
            out_entry_valid_r <= 1'b1;
            out_entry_r       <= c0;
            out_last_r        <= (dump_idx_r == count_r - CNT_W'(1));
            dump_idx_r        <= dump_idx_r + CNT_W'(1);
            if (dump_idx_r == count_r - CNT_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status_r      <= status_r;
            out_count_r       <= count_r;
            out_entry_valid_r <= 1'b0;
            out_entry_r       <= '0;
            out_last_r        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_bottom      = out_entry_r.bottom;
  assign out_top         = out_entry_r.top;
  assign out_floor_tag   = out_entry_r.ftag;
  assign out_ceiling_tag = out_entry_r.ctag;
  assign out_last        = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |-> tail_r <= CNT_W'(DEPTH))
    else $error("merge tail past the chain");

  a_multi_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_entry_valid_r)
    else $error("non-final word outside a dump");

  a_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_entry_valid_r |-> out_status_r == sui_pkg::ST_OK)
    else $error("dump word with bad status");

endmodule
